// ----- hdl/wpmm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpmm_pkg: shared definitions of the 2x2 window pooling unit
// Sample and partial widths, output field widths, pooling mode codes and
// the default feature map geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package wpmm_pkg;

	localparam int SAMPLE_BITS = 16;
	// A window partial holds the sum of four samples without loss.
	localparam int PART_BITS = SAMPLE_BITS + 2;
	localparam int CHAN_IDX_BITS = 4;
	localparam int OUT_POS_BITS = 2;
	localparam int MODE_BITS = 2;

	// Pooling mode codes. The unused code behaves as maximum.
	localparam logic [MODE_BITS-1:0] MODE_MEAN = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_MAX;

	localparam int CHANNELS_DEF = 16;
	localparam int ROWS_IN_DEF = 8;
	localparam int COLS_IN_DEF = 8;

endpackage

`default_nettype wire

// ----- hdl/wpmm_feat_if.sv -----
// ----------------------------------------------------------------------------
// wpmm_feat_if: feature sample channel
// Carries one signed feature sample per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpmm_feat_if import wpmm_pkg::*; ();

	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);

endinterface

`default_nettype wire

// ----- hdl/wpmm_pooled_if.sv -----
// ----------------------------------------------------------------------------
// wpmm_pooled_if: pooled result channel
// Carries one pooled value with its channel, output position and end-of-map
// flag per item, with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpmm_pooled_if import wpmm_pkg::*; ();

	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] pooled_value;
	logic [CHAN_IDX_BITS-1:0] channel_index;
	logic [OUT_POS_BITS-1:0] out_row;
	logic [OUT_POS_BITS-1:0] out_col;
	logic map_done;

	modport source (
		output valid, output pooled_value, output channel_index,
		output out_row, output out_col, output map_done, input ready
	);
	modport sink (
		input valid, input pooled_value, input channel_index,
		input out_row, input out_col, input map_done, output ready
	);

endinterface

`default_nettype wire

// ----- hdl/wpmm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// wpmm_cfg_if: configuration write channel
// Carries a new pooling mode per write with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpmm_cfg_if import wpmm_pkg::*; ();

	logic valid;
	logic ready;
	logic [MODE_BITS-1:0] pool_mode;

	modport source (output valid, output pool_mode, input ready);
	modport sink (input valid, input pool_mode, output ready);

endinterface

`default_nettype wire

// ----- hdl/window_pool_mean_min_max_unit.sv -----
// ----------------------------------------------------------------------------
// window_pool_mean_min_max_unit: streaming 2x2 mean/min/max pooling
// Pools non-overlapping 2x2 windows per channel of a feature map that
// arrives in row, column, channel order, and emits one result per window.
// ----------------------------------------------------------------------------
//
//  Port    Role   Payload                                          Per item
//  ------  -----  -----------------------------------------------  -----------
//  feat    sink   sample                                           one sample
//  pooled  source pooled_value, channel_index, out_row, out_col,   one window
//                 map_done
//  cfg     sink   pool_mode                                        one write
//
// The unit accepts one sample in every clock cycle unless a held result
// stalls its input. A sample is taken into stage one together with its
// window partial, which is read from the partial memory as it is accepted;
// when stage one moves on, the updated partial is written back and, on a
// window's last sample, the result register is loaded from stage one. A
// write that lands on the entry being read in the same cycle is forwarded
// around the memory.
// Reset clears the stream position, the valid flags and sets the mode to
// maximum; the partial memory is not cleared, because every window's first
// sample writes its entry before it is read. When the result register is
// full and not taken, stage one holds if it carries a result, and input
// stalls behind it; samples without a result keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module window_pool_mean_min_max_unit import wpmm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int ROWS_IN = ROWS_IN_DEF,
	parameter int COLS_IN = COLS_IN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	wpmm_feat_if.sink feat,
	wpmm_pooled_if.source pooled,
	wpmm_cfg_if.sink cfg
);

	// Geometry. Rows and columns that do not complete a window are skipped.
	localparam int OUT_ROWS = ROWS_IN / 2;
	localparam int OUT_COLS = COLS_IN / 2;
	localparam int ROWS_USED = 2 * OUT_ROWS;
	localparam int COLS_USED = 2 * OUT_COLS;
	localparam int PART_DEPTH = OUT_COLS * CHANNELS;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RW = $clog2(ROWS_IN);
	localparam int CW = $clog2(COLS_IN);
	localparam int AW = (PART_DEPTH > 1) ? $clog2(PART_DEPTH) : 1;

	// Stream position of the next sample.
	logic [CH_W-1:0] ch_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [MODE_BITS-1:0] mode_q;

	// Stage one: the accepted sample, its partial and its window bookkeeping.
	logic s1_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic signed [PART_BITS-1:0] part_s1;
	logic [AW-1:0] addr_s1;
	logic use_s1;
	logic first_s1;
	logic emit_s1;
	logic done_s1;
	logic [MODE_BITS-1:0] mode_s1;
	logic [CHAN_IDX_BITS-1:0] chan_s1;
	logic [OUT_POS_BITS-1:0] orow_s1;
	logic [OUT_POS_BITS-1:0] ocol_s1;

	// Result register.
	logic out_valid_q;
	logic signed [SAMPLE_BITS-1:0] res_value_q;
	logic [CHAN_IDX_BITS-1:0] res_chan_q;
	logic [OUT_POS_BITS-1:0] res_row_q;
	logic [OUT_POS_BITS-1:0] res_col_q;
	logic res_done_q;

	// Window partials, one per output column and channel of the open row pair.
	logic signed [PART_BITS-1:0] part_mem [PART_DEPTH];

	logic in_fire;
	logic out_free;
	logic s1_go;
	logic load_out;
	logic wr_en;
	logic [AW-1:0] rd_addr;
	logic in_range;
	logic is_first;
	logic is_last;
	logic is_done;
	logic ch_wrap;
	logic col_wrap;
	logic row_wrap;
	logic [CH_W+CHAN_IDX_BITS-1:0] ch_wide;
	logic [RW+OUT_POS_BITS-1:0] row_wide;
	logic [CW+OUT_POS_BITS-1:0] col_wide;
	logic signed [PART_BITS-1:0] s_ext;
	logic signed [PART_BITS-1:0] p_new;
	logic signed [SAMPLE_BITS-1:0] value_new;

	// Handshakes. Stage one moves on unless it carries a result that the
	// full result register cannot take.
	assign out_free = !out_valid_q || pooled.ready;
	assign s1_go = s1_valid_q && (!emit_s1 || out_free);
	assign feat.ready = !s1_valid_q || s1_go;
	assign in_fire = feat.valid && feat.ready;
	assign load_out = s1_go && emit_s1;
	assign wr_en = s1_go && use_s1;
	assign cfg.ready = 1'b1;

	// Position decode of the incoming sample.
	assign in_range = (row_q <= RW'(ROWS_USED - 1)) && (col_q <= CW'(COLS_USED - 1));
	assign is_first = !row_q[0] && !col_q[0];
	assign is_last = row_q[0] && col_q[0];
	assign is_done = (row_q == RW'(ROWS_USED - 1)) && (col_q == CW'(COLS_USED - 1))
		&& (ch_q == CH_W'(CHANNELS - 1));
	assign rd_addr = AW'((int'(col_q) >> 1) * CHANNELS + int'(ch_q));
	assign ch_wide = {{CHAN_IDX_BITS{1'b0}}, ch_q};
	assign row_wide = {{OUT_POS_BITS{1'b0}}, row_q};
	assign col_wide = {{OUT_POS_BITS{1'b0}}, col_q};

	assign ch_wrap = (ch_q == CH_W'(CHANNELS - 1));
	assign col_wrap = (col_q == CW'(COLS_IN - 1));
	assign row_wrap = (row_q == RW'(ROWS_IN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (ch_wrap) begin
				ch_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			mode_q <= cfg.pool_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (feat.ready) begin
			s1_valid_q <= feat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= feat.sample;
			addr_s1 <= rd_addr;
			use_s1 <= in_range;
			first_s1 <= is_first;
			emit_s1 <= in_range && is_last;
			done_s1 <= is_done;
			mode_s1 <= mode_q;
			chan_s1 <= ch_wide[CHAN_IDX_BITS-1:0];
			orow_s1 <= row_wide[OUT_POS_BITS:1];
			ocol_s1 <= col_wide[OUT_POS_BITS:1];
		end
	end

	// Partial memory: one write and one registered read a cycle, with the
	// write forwarded when both touch the same entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			part_mem[addr_s1] <= p_new;
		end
		if (in_fire) begin
			if (wr_en && (addr_s1 == rd_addr)) begin
				part_s1 <= p_new;
			end else begin
				part_s1 <= part_mem[rd_addr];
			end
		end
	end

	// Combine the sample into its window partial. A window's first sample
	// seeds the partial in every mode; the sum wraps within the partial.
	always_comb begin
		s_ext = PART_BITS'(sample_s1);
		if (first_s1) begin
			p_new = s_ext;
		end else begin
			case (mode_s1)
				MODE_MEAN: p_new = part_s1 + s_ext;
				MODE_MIN: p_new = (s_ext < part_s1) ? s_ext : part_s1;
				default: p_new = (s_ext > part_s1) ? s_ext : part_s1;
			endcase
		end
		// The mean drops two bits, which floors the quarter of the sum.
		if (mode_s1 == MODE_MEAN) begin
			value_new = p_new[PART_BITS-1:2];
		end else begin
			value_new = p_new[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pooled.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_value_q <= value_new;
			res_chan_q <= chan_s1;
			res_row_q <= orow_s1;
			res_col_q <= ocol_s1;
			res_done_q <= done_s1;
		end
	end

	assign pooled.valid = out_valid_q;
	assign pooled.pooled_value = res_value_q;
	assign pooled.channel_index = res_chan_q;
	assign pooled.out_row = res_row_q;
	assign pooled.out_col = res_col_q;
	assign pooled.map_done = res_done_q;

endmodule

`default_nettype wire

// ----- hdl/wpmm_checker.sv -----
// ----------------------------------------------------------------------------
// wpmm_checker: port-level checks of the pooling unit
// Watches the sample and result channels and is bound to the unit below.
// ----------------------------------------------------------------------------
`default_nettype none

module wpmm_checker import wpmm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int ROWS_IN = ROWS_IN_DEF,
	parameter int COLS_IN = COLS_IN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [SAMPLE_BITS-1:0] out_value,
	input wire logic [CHAN_IDX_BITS-1:0] out_chan,
	input wire logic [OUT_POS_BITS-1:0] out_row,
	input wire logic [OUT_POS_BITS-1:0] out_col,
	input wire logic out_done
);

	localparam logic [CHAN_IDX_BITS-1:0] LAST_CHAN = CHAN_IDX_BITS'(CHANNELS - 1);
	localparam logic [OUT_POS_BITS-1:0] LAST_ROW = OUT_POS_BITS'(ROWS_IN / 2 - 1);
	localparam logic [OUT_POS_BITS-1:0] LAST_COL = OUT_POS_BITS'(COLS_IN / 2 - 1);

	// A result that waits keeps its value, channel and end-of-map flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_chan) && $stable(out_done))
		else $error("pooled result changed while stalled");

	// The end-of-map result belongs to the last channel and last window.
	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_done |-> (out_chan == LAST_CHAN) && (out_row == LAST_ROW)
			&& (out_col == LAST_COL))
		else $error("map_done on a result that is not the last window");

	// A result appearing on an empty output follows an accepted sample.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("pooled result without a preceding sample");

endmodule

bind window_pool_mean_min_max_unit wpmm_checker #(
	.CHANNELS(CHANNELS),
	.ROWS_IN(ROWS_IN),
	.COLS_IN(COLS_IN)
) u_wpmm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(feat.valid),
	.in_ready(feat.ready),
	.out_valid(pooled.valid),
	.out_ready(pooled.ready),
	.out_value(pooled.pooled_value),
	.out_chan(pooled.channel_index),
	.out_row(pooled.out_row),
	.out_col(pooled.out_col),
	.out_done(pooled.map_done)
);

`default_nettype wire

// ----- test/wpmm_pool_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpmm_pool_checker: scoreboard for the 2x2 window pooling unit
// Follows the accepted sample stream and mode writes, predicts every pooled
// item and compares it field by field with what the unit delivers.
// ----------------------------------------------------------------------------

module wpmm_pool_checker import wpmm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int ROWS_IN = ROWS_IN_DEF,
	parameter int COLS_IN = COLS_IN_DEF
) (
	input logic clk,
	input logic arst_n,
	wpmm_feat_if feat,
	wpmm_pooled_if pooled,
	wpmm_cfg_if cfg,
	output int fail_count,
	output int results_waiting
);

	localparam int OUT_ROWS = ROWS_IN / 2;
	localparam int OUT_COLS = COLS_IN / 2;
	localparam int PART_DEPTH = OUT_COLS * CHANNELS;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic [CHAN_IDX_BITS-1:0] chan;
		logic [OUT_POS_BITS-1:0] orow;
		logic [OUT_POS_BITS-1:0] ocol;
		logic last;
	} window_result_t;

	window_result_t window_q[$];
	logic signed [PART_BITS-1:0] partial_mem [PART_DEPTH];
	logic [MODE_BITS-1:0] mode_now;
	int row_pos;
	int col_pos;
	int chan_pos;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		fail_count++;
	endtask

	// Folds one sample into its window partial and queues the pooled item
	// when the sample closes a window.
	task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] s);
		logic signed [PART_BITS-1:0] s_wide;
		logic signed [PART_BITS-1:0] part;
		logic signed [PART_BITS-1:0] quarter;
		window_result_t res;
		int slot;
		int orow;
		int ocol;
		s_wide = s;
		orow = row_pos / 2;
		ocol = col_pos / 2;
		if (orow < OUT_ROWS && ocol < OUT_COLS) begin
			slot = ocol * CHANNELS + chan_pos;
			if (row_pos % 2 == 0 && col_pos % 2 == 0) begin
				part = s_wide;
			end else begin
				part = partial_mem[slot];
				case (mode_now)
				MODE_MEAN: part = part + s_wide;
				MODE_MIN: part = (s_wide < part) ? s_wide : part;
				default: part = (s_wide > part) ? s_wide : part;
				endcase
			end
			partial_mem[slot] = part;
			if (row_pos % 2 == 1 && col_pos % 2 == 1) begin
				quarter = part >>> 2;
				res.value = (mode_now == MODE_MEAN) ? quarter[SAMPLE_BITS-1:0]
					: part[SAMPLE_BITS-1:0];
				res.chan = chan_pos[CHAN_IDX_BITS-1:0];
				res.orow = orow[OUT_POS_BITS-1:0];
				res.ocol = ocol[OUT_POS_BITS-1:0];
				res.last = (orow == OUT_ROWS - 1 && ocol == OUT_COLS - 1
					&& chan_pos == CHANNELS - 1);
				window_q.push_back(res);
			end
		end
		chan_pos++;
		if (chan_pos >= CHANNELS) begin
			chan_pos = 0;
			col_pos++;
			if (col_pos >= COLS_IN) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= ROWS_IN) begin
					row_pos = 0;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_result_t want;
		window_result_t seen;
		if (!arst_n) begin
			window_q.delete();
			mode_now = MODE_RESET;
			row_pos = 0;
			col_pos = 0;
			chan_pos = 0;
			fail_count = 0;
			results_waiting = 0;
		end else begin
			if (pooled.valid && pooled.ready) begin
				seen.value = pooled.pooled_value;
				seen.chan = pooled.channel_index;
				seen.orow = pooled.out_row;
				seen.ocol = pooled.out_col;
				seen.last = pooled.map_done;
				if (window_q.size() == 0) begin
					report_mismatch($sformatf("pooled item %0d ch%0d (%0d,%0d) with no window closed",
						$signed(seen.value), seen.chan, seen.orow, seen.ocol));
				end else begin
					want = window_q.pop_front();
					if (seen.value !== want.value || seen.chan !== want.chan
						|| seen.orow !== want.orow || seen.ocol !== want.ocol
						|| seen.last !== want.last) begin
						report_mismatch($sformatf(
							"got %0d ch%0d (%0d,%0d) done%0b, want %0d ch%0d (%0d,%0d) done%0b",
							$signed(seen.value), seen.chan, seen.orow, seen.ocol, seen.last,
							$signed(want.value), want.chan, want.orow, want.ocol, want.last));
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				mode_now = cfg.pool_mode;
			end
			if (feat.valid && feat.ready) begin
				absorb_sample(feat.sample);
			end
			results_waiting = window_q.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for window_pool_mean_min_max_unit
// Streams feature samples through the pooling unit in phases, each under a
// freshly written pooling mode, with random gaps on both handshakes, and lets
// a scoreboard check every pooled item against its own prediction.
// ----------------------------------------------------------------------------

module tb_top import wpmm_pkg::*; ();

	// The package only names the three real modes; the spare code is expected
	// to pool as maximum.
	localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

	localparam int RESET_CYCLES = 7;
	localparam int DIRECTED_LEN = 25;
	// Enough samples for several mode phases and the long hold-off; the last
	// phase may run a little past this mark.
	localparam int SAMPLE_TARGET = 800;
	localparam int HOLD_PHASE = 5;
	localparam int HOLD_QUOTA = 320;
	localparam int LONG_HOLD = 400;
	// A result passes through stage one into the result register; the extra
	// settling lets a sample that closes no window finish its write-back.
	localparam int PIPE_SETTLE = 6;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {
		MIX_FULL,
		MIX_EDGES,
		MIX_TOP,
		MIX_BOTTOM,
		MIX_NEAR_ZERO
	} sample_mix_e;

	logic clk = 1'b0;
	logic arst_n;
	int cycle_count = 0;
	int samples_sent = 0;
	int fail_count;
	int results_waiting;
	logic hold_off_req = 1'b0;

	wpmm_feat_if feat_bus ();
	wpmm_pooled_if pooled_bus ();
	wpmm_cfg_if cfg_bus ();

	window_pool_mean_min_max_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.feat(feat_bus),
		.pooled(pooled_bus),
		.cfg(cfg_bus)
	);

	wpmm_pool_checker #(
		.CHANNELS(CHANNELS_DEF),
		.ROWS_IN(ROWS_IN_DEF),
		.COLS_IN(COLS_IN_DEF)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.feat(feat_bus),
		.pooled(pooled_bus),
		.cfg(cfg_bus),
		.fail_count(fail_count),
		.results_waiting(results_waiting)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The watchdog: a hung handshake or a window that never comes out ends
	// the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles", cycle_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Mostly back-to-back, often a short gap, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			return 0;
		end else if (roll < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Full-scale values, zero, the values next to them and alternating bits.
	function automatic logic [SAMPLE_BITS-1:0] edge_sample(input int k);
		case (k % 10)
		0: return 16'h7FFF;
		1: return 16'h8000;
		2: return 16'h0000;
		3: return 16'hFFFF;
		4: return 16'h0001;
		5: return 16'h8001;
		6: return 16'h7FFE;
		7: return 16'h5555;
		8: return 16'hAAAA;
		default: return 16'hFFFE;
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_mix_e mix);
		case (mix)
		MIX_EDGES: return edge_sample($urandom_range(0, 9));
		MIX_TOP: return 16'h7FFF;
		MIX_BOTTOM: return 16'h8000;
		MIX_NEAR_ZERO: return SAMPLE_BITS'($urandom_range(0, 16)) - 16'd8;
		default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the item was
	// taken, with valid still high so the next item can follow without a gap.
	task automatic send_feature(input logic [SAMPLE_BITS-1:0] value, input int gap);
		if (gap > 0) begin
			feat_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		feat_bus.valid <= 1'b1;
		feat_bus.sample <= value;
		do @(posedge clk); while (!feat_bus.ready);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic write_mode(input logic [MODE_BITS-1:0] mode);
		cfg_bus.valid <= 1'b1;
		cfg_bus.pool_mode <= mode;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Stops offering samples and waits until every closed window has come
	// out, then lets the pipeline empty before the mode may change.
	task automatic settle_idle();
		feat_bus.valid <= 1'b0;
		while (results_waiting != 0) @(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	// Result side: random stalls, runs of steady readiness, and one long
	// hold-off that backs the unit up into its input.
	initial begin
		int stall_left;
		int free_left;
		int held;
		bit hold_done;
		stall_left = 0;
		free_left = 0;
		hold_done = 1'b0;
		pooled_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				pooled_bus.ready <= 1'b0;
				for (held = 1; held < LONG_HOLD; held++) begin
					@(negedge clk);
				end
				hold_done = 1'b1;
			end else if (stall_left > 0) begin
				pooled_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				pooled_bus.ready <= 1'b1;
				if (free_left > 0) begin
					free_left--;
				end else if ($urandom_range(0, 7) == 0) begin
					free_left = $urandom_range(20, 150);
				end else begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// Sample side and mode writes.
	initial begin
		int phase;
		int quota;
		int i;
		int roll;
		bit quiet;
		logic [MODE_BITS-1:0] mode_sel;
		sample_mix_e mix;
		feat_bus.valid = 1'b0;
		feat_bus.sample = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.pool_mode = MODE_RESET;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening under the reset mode: the extreme values seed the
		// first windows of row zero, and the odd-column ones are combined by
		// maximum before any mode has been written.
		for (i = 0; i < DIRECTED_LEN; i++) begin
			send_feature(edge_sample(i), (i % 6 == 5) ? 2 : 0);
		end
		settle_idle();

		// Random phases. The stream position carries across phases, so a
		// phase usually ends inside open windows and the next mode finishes
		// them; this is how a mode change in the middle of a window is hit.
		phase = 0;
		while (samples_sent < SAMPLE_TARGET) begin
			if (phase < 8) begin
				case (phase % 4)
				0: mode_sel = MODE_MEAN;
				1: mode_sel = MODE_MIN;
				2: mode_sel = MODE_MAX;
				default: mode_sel = MODE_SPARE;
				endcase
			end else begin
				mode_sel = MODE_BITS'($urandom_range(0, 3));
			end
			write_mode(mode_sel);

			roll = $urandom_range(0, 9);
			if (roll < 4) begin
				mix = MIX_FULL;
			end else if (roll < 6) begin
				mix = MIX_EDGES;
			end else if (roll == 6) begin
				mix = MIX_TOP;
			end else if (roll == 7) begin
				mix = MIX_BOTTOM;
			end else begin
				mix = MIX_NEAR_ZERO;
			end
			quiet = ($urandom_range(0, 3) == 0);
			quota = $urandom_range(8, 120);

			// One long phase keeps offering samples back to back while the
			// result side holds off, so the unit fills and stalls its input.
			if (phase == HOLD_PHASE) begin
				quota = HOLD_QUOTA;
				quiet = 1'b1;
				mix = MIX_FULL;
				hold_off_req <= 1'b1;
			end

			for (i = 0; i < quota; i++) begin
				send_feature(pick_sample(mix), quiet ? 0 : pick_gap());
			end
			settle_idle();
			phase++;
		end

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/wpmm_pkg.sv
hdl/wpmm_feat_if.sv
hdl/wpmm_pooled_if.sv
hdl/wpmm_cfg_if.sv
hdl/window_pool_mean_min_max_unit.sv
hdl/wpmm_checker.sv
test/wpmm_pool_checker.sv
test/tb_top.sv
